/* design/fpts_pkg.sv */
// package: types and constants for the fixed priority task scheduler
package fpts_pkg;
  localparam int Levels = 8;
  localparam int Slots = 16;
  localparam int LvW = $clog2(Levels);
  localparam int TkW = $clog2(Slots);
  localparam logic [15:0] QuantumReset = 16'd2;

  localparam logic [2:0] OP_PICK = 3'd0;
  localparam logic [2:0] OP_ENQ = 3'd1;
  localparam logic [2:0] OP_DEQ = 3'd2;
  localparam logic [2:0] OP_YIELD = 3'd3;
  localparam logic [2:0] OP_SETP = 3'd4;
  localparam logic [2:0] OP_TICK = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_QUEUED = 2'd2;
  localparam logic [1:0] ST_NOTQ = 2'd3;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] task_id;
    logic [3:0] new_priority;
    logic [3:0] current_task;
    logic current_valid;
    logic [15:0] blocked_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] picked_task;
    logic picked_valid;
    logic resched_request;
  } out_item_t;
endpackage

/* design/fixed_priority_task_scheduler_unit.sv */
// top level: per-level linked fifos over task slots with a step sequencer
// tick, invalid, queued and not queued requests go from decode straight to the result; enqueue appends first
// pick walks one slot or one empty level per cycle; unlink walks one slot per cycle for
// dequeue, yield and set priority, and yield or set priority then re-append the task
// throughput: one request at a time, busy high until out_valid pulses, receiver cannot stall
// reset: synchronous active low, clears queue flags and loads ticks_r and quantum_r with 2
module fixed_priority_task_scheduler_unit
  import fpts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_item_t in_item,
  output logic out_valid,
  output out_item_t out_item,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [15:0] cfg_data
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC = 7'b0000010,
    S_PICK = 7'b0000100,
    S_UNL = 7'b0001000,
    S_PUT = 7'b0010000,
    S_DONE = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;

  state_t st_r;
  in_item_t req_r;
  logic [TkW-1:0] head_r [Levels];
  logic [TkW-1:0] tail_r [Levels];
  logic [Levels-1:0] ne_r;
  logic [TkW-1:0] link_r [Slots];
  logic [LvW-1:0] lvl_r [Slots];
  logic [Slots-1:0] q_r;
  logic [15:0] ticks_r, quantum_r;
  out_item_t res_r;
  logic [LvW-1:0] lv_r;    // level being scanned or target level
  logic [TkW-1:0] t_r;     // task being moved
  logic [TkW-1:0] p_r;     // walk pointer
  logic [4:0] n_r;
  logic reload_r;

  assign busy = (st_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (st_r == S_OUT);
  assign out_item = res_r;

  // highest nonempty level
  logic [LvW-1:0] top_lv;
  logic top_ok;
  always_comb begin
    top_lv = '0;
    top_ok = 1'b0;
    for (int i = 0; i < Levels; i++) begin
      if (ne_r[i]) begin
        top_lv = LvW'(i);
        top_ok = 1'b1;
      end
    end
  end

  logic [TkW-1:0] tsk, cur;
  logic [TkW-1:0] nx;
  assign tsk = req_r.task_id[TkW-1:0];
  assign cur = req_r.current_task[TkW-1:0];
  assign nx = link_r[p_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ne_r <= '0;
      q_r <= '0;
      ticks_r <= QuantumReset;
      quantum_r <= QuantumReset;
    end else begin
      if (cfg_valid) quantum_r <= cfg_data;
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            req_r <= in_item;
            res_r <= '0;
            st_r <= S_DEC;
          end
        end
        S_DEC: begin
          reload_r <= (req_r.opcode == OP_YIELD);
          unique case (req_r.opcode)
            OP_PICK: begin
              lv_r <= LvW'(Levels - 1);
              p_r <= head_r[Levels-1];
              n_r <= '0;
              st_r <= S_PICK;
            end
            OP_ENQ: begin
              if (q_r[tsk]) begin
                res_r.status <= ST_QUEUED;
                st_r <= S_OUT;
              end else begin
                t_r <= tsk;
                lv_r <= '0;
                st_r <= S_PUT;
              end
            end
            OP_DEQ: begin
              if (!q_r[tsk]) begin
                res_r.status <= ST_NOTQ;
                st_r <= S_OUT;
              end else begin
                t_r <= tsk;
                lv_r <= lvl_r[tsk];
                p_r <= head_r[lvl_r[tsk]];
                n_r <= '0;
                st_r <= S_UNL;
              end
            end
            OP_YIELD: begin
              if (req_r.current_valid && q_r[cur]) begin
                t_r <= cur;
                lv_r <= lvl_r[cur];
                p_r <= head_r[lvl_r[cur]];
                n_r <= '0;
                st_r <= S_UNL;
              end else if (top_ok) begin
                t_r <= head_r[top_lv];
                lv_r <= top_lv;
                p_r <= head_r[top_lv];
                n_r <= '0;
                st_r <= S_UNL;
              end else st_r <= S_OUT;
            end
            OP_SETP: begin
              if (req_r.new_priority >= 4'(Levels)) begin
                res_r.status <= ST_INVALID;
                st_r <= S_OUT;
              end else if (!q_r[tsk]) begin
                res_r.status <= ST_NOTQ;
                st_r <= S_OUT;
              end else if (lvl_r[tsk] != req_r.new_priority[LvW-1:0]) begin
                t_r <= tsk;
                lv_r <= lvl_r[tsk];
                p_r <= head_r[lvl_r[tsk]];
                n_r <= '0;
                st_r <= S_UNL;
              end else st_r <= S_OUT;
            end
            OP_TICK: begin
              if (req_r.current_valid) begin
                if (ticks_r <= 16'd1) begin
                  res_r.resched_request <= 1'b1;
                  ticks_r <= quantum_r;
                end else ticks_r <= ticks_r - 16'd1;
              end
              st_r <= S_OUT;
            end
            default: begin
              res_r.status <= ST_INVALID;
              st_r <= S_OUT;
            end
          endcase
        end
        S_PICK: begin
          // one slot per cycle, then next lower level
          if (!ne_r[lv_r] || p_r == tail_r[lv_r] || n_r == 5'(Slots - 1)
              || !req_r.blocked_mask[p_r]) begin
            if (ne_r[lv_r] && !req_r.blocked_mask[p_r]) begin
              res_r.picked_task <= p_r;
              res_r.picked_valid <= 1'b1;
              st_r <= S_OUT;
            end else if (lv_r == '0) st_r <= S_OUT;
            else begin
              lv_r <= lv_r - 1'b1;
              p_r <= head_r[lv_r - 1'b1];
              n_r <= '0;
            end
          end else begin
            p_r <= nx;
            n_r <= n_r + 5'd1;
          end
        end
        S_UNL: begin
          // unlink t_r from level lv_r, walking predecessors
          q_r[t_r] <= 1'b0;
          if (!ne_r[lv_r]) st_r <= S_DONE;
          else if (head_r[lv_r] == t_r) begin
            if (tail_r[lv_r] == t_r) ne_r[lv_r] <= 1'b0;
            else head_r[lv_r] <= link_r[t_r];
            st_r <= S_DONE;
          end else if (nx == t_r) begin
            link_r[p_r] <= link_r[t_r];
            if (tail_r[lv_r] == t_r) tail_r[lv_r] <= p_r;
            st_r <= S_DONE;
          end else if (p_r == tail_r[lv_r] || n_r == 5'(Slots - 1)) st_r <= S_DONE;
          else begin
            p_r <= nx;
            n_r <= n_r + 5'd1;
          end
        end
        S_DONE: begin
          // choose target level for the re-append
          if (req_r.opcode == OP_DEQ) st_r <= S_OUT;
          else begin
            if (req_r.opcode == OP_SETP) lv_r <= req_r.new_priority[LvW-1:0];
            st_r <= S_PUT;
          end
        end
        S_PUT: begin
          if (ne_r[lv_r]) begin
            link_r[tail_r[lv_r]] <= t_r;
            tail_r[lv_r] <= t_r;
          end else begin
            head_r[lv_r] <= t_r;
            tail_r[lv_r] <= t_r;
            ne_r[lv_r] <= 1'b1;
          end
          lvl_r[t_r] <= lv_r;
          q_r[t_r] <= 1'b1;
          if (reload_r) ticks_r <= quantum_r;
          st_r <= S_OUT;
        end
        S_OUT: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request not taken");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.picked_valid |-> req_r.opcode == OP_PICK)
    else $error("picked_valid outside pick");
endmodule

/* tb/fpts_checker.sv */
// checker: predicts scheduler results from observed requests and compares them
module fpts_checker
  import fpts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [15:0] cfg_data,
  output int        errors,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [TkW-1:0] lv_head [Levels];
  logic [TkW-1:0] lv_tail [Levels];
  logic           lv_busy [Levels];
  logic [TkW-1:0] link    [Slots];
  logic [LvW-1:0] slot_lv [Slots];
  logic           queued  [Slots];
  logic [15:0]    ticks_left;
  logic [15:0]    quantum;
  out_item_t      expected_q[$];

  function automatic void append_task(input logic [TkW-1:0] t, input logic [LvW-1:0] lv);
    if (lv_busy[lv]) begin
      link[lv_tail[lv]] = t;
      lv_tail[lv] = t;
    end else begin
      lv_head[lv] = t;
      lv_tail[lv] = t;
      lv_busy[lv] = 1'b1;
    end
    slot_lv[t] = lv;
    queued[t] = 1'b1;
  endfunction

  function automatic void unlink_task(input logic [TkW-1:0] t);
    logic [LvW-1:0] lv;
    logic [TkW-1:0] p, nx;
    lv = slot_lv[t];
    queued[t] = 1'b0;
    if (!lv_busy[lv]) return;
    if (lv_head[lv] == t) begin
      if (lv_tail[lv] == t) lv_busy[lv] = 1'b0;
      else lv_head[lv] = link[t];
      return;
    end
    p = lv_head[lv];
    for (int n = 0; n < Slots; n++) begin
      nx = link[p];
      if (nx == t) begin
        link[p] = link[t];
        if (lv_tail[lv] == t) lv_tail[lv] = p;
        return;
      end
      if (p == lv_tail[lv]) return;
      p = nx;
    end
  endfunction

  function automatic out_item_t schedule_step(input in_item_t rq);
    out_item_t r;
    logic [TkW-1:0] t;
    logic [LvW-1:0] lv;
    r = '0;
    r.status = ST_OK;
    case (rq.opcode)
      OP_PICK: begin
        for (int i = Levels - 1; i >= 0 && !r.picked_valid; i--) begin
          if (lv_busy[i]) begin
            t = lv_head[i];
            for (int n = 0; n < Slots; n++) begin
              if (!rq.blocked_mask[t]) begin
                r.picked_task = t;
                r.picked_valid = 1'b1;
                break;
              end
              if (t == lv_tail[i]) break;
              t = link[t];
            end
          end
        end
      end
      OP_ENQ: begin
        if (queued[rq.task_id]) r.status = ST_QUEUED;
        else append_task(rq.task_id, '0);
      end
      OP_DEQ: begin
        if (!queued[rq.task_id]) r.status = ST_NOTQ;
        else unlink_task(rq.task_id);
      end
      OP_YIELD: begin
        if (rq.current_valid && queued[rq.current_task]) begin
          lv = slot_lv[rq.current_task];
          unlink_task(rq.current_task);
          append_task(rq.current_task, lv);
          ticks_left = quantum;
        end else begin
          for (int i = Levels - 1; i >= 0; i--) begin
            if (lv_busy[i]) begin
              t = lv_head[i];
              unlink_task(t);
              append_task(t, LvW'(i));
              ticks_left = quantum;
              break;
            end
          end
        end
      end
      OP_SETP: begin
        if (rq.new_priority >= Levels) r.status = ST_INVALID;
        else if (!queued[rq.task_id]) r.status = ST_NOTQ;
        else if (slot_lv[rq.task_id] != rq.new_priority[LvW-1:0]) begin
          unlink_task(rq.task_id);
          append_task(rq.task_id, rq.new_priority[LvW-1:0]);
        end
      end
      OP_TICK: begin
        if (rq.current_valid) begin
          if (ticks_left != 0) ticks_left = ticks_left - 16'd1;
          if (ticks_left == 0) begin
            r.resched_request = 1'b1;
            ticks_left = quantum;
          end
        end
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  initial errors = 0;
  assign outstanding = expected_q.size();

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      for (int i = 0; i < Levels; i++) begin
        lv_head[i] = '0;
        lv_tail[i] = '0;
        lv_busy[i] = 1'b0;
      end
      for (int i = 0; i < Slots; i++) begin
        link[i] = '0;
        slot_lv[i] = '0;
        queued[i] = 1'b0;
      end
      ticks_left = QuantumReset;
      quantum = QuantumReset;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, out_item);
          errors = errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_item.status !== e.status || out_item.picked_task !== e.picked_task ||
              out_item.picked_valid !== e.picked_valid ||
              out_item.resched_request !== e.resched_request) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, e, out_item);
            errors = errors + 1;
          end
        end
      end
      if (start && !busy) expected_q.push_back(schedule_step(in_item));
      if (cfg_valid && cfg_ready) quantum = cfg_data;
    end
  end
endmodule

/* tb/tb_fixed_priority_task_scheduler_unit.sv */
// testbench top: drives scheduler requests and quantum writes, reports the verdict
module tb_fixed_priority_task_scheduler_unit;
  import fpts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  int errors;
  int outstanding;
  bit idling = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fixed_priority_task_scheduler_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  fpts_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [2:0] op, input logic [3:0] tid,
                              input logic [3:0] prio, input logic [3:0] cur,
                              input logic cv, input logic [15:0] mask);
    if (idling && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 15)) @(negedge clk);
    while (busy) @(negedge clk);
    start = 1'b1;
    in_item = '{op, tid, prio, cur, cv, mask};
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic write_quantum(input logic [15:0] q);
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = q;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_request();
    logic [2:0] op;
    logic [15:0] mask;
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) op = OP_PICK;
    else if (r < 40) op = OP_ENQ;
    else if (r < 50) op = OP_DEQ;
    else if (r < 62) op = OP_YIELD;
    else if (r < 82) op = OP_SETP;
    else if (r < 97) op = OP_TICK;
    else op = 3'($urandom_range(6, 7));
    case ($urandom_range(0, 3))
      0: mask = '0;
      1: mask = 16'($urandom) & 16'($urandom) & 16'($urandom);
      2: mask = 16'($urandom);
      default: mask = ~(16'($urandom) & 16'($urandom));
    endcase
    send_request(op, 4'($urandom), ($urandom_range(0, 5) == 0) ? 4'($urandom) :
                 4'($urandom_range(0, 7)), 4'($urandom), ($urandom_range(0, 4) != 0), mask);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    // edge cases: duplicates, empty queues, bad levels, blocked picks
    send_request(OP_PICK, 4'd0, 4'd0, 4'd0, 1'b0, 16'h0000);
    send_request(OP_YIELD, 4'd0, 4'd0, 4'd0, 1'b0, 16'h0000);
    send_request(OP_DEQ, 4'd15, 4'd0, 4'd0, 1'b0, 16'h0000);
    send_request(OP_SETP, 4'd3, 4'd2, 4'd0, 1'b0, 16'h0000);
    send_request(OP_ENQ, 4'd0, 4'd0, 4'd0, 1'b0, 16'h0000);
    send_request(OP_ENQ, 4'd15, 4'd0, 4'd0, 1'b0, 16'h0000);
    send_request(OP_ENQ, 4'd5, 4'd0, 4'd0, 1'b0, 16'h0000);
    send_request(OP_ENQ, 4'd15, 4'd0, 4'd0, 1'b0, 16'h0000);
    send_request(OP_SETP, 4'd15, 4'd8, 4'd0, 1'b0, 16'h0000);
    send_request(OP_SETP, 4'd15, 4'd15, 4'd0, 1'b0, 16'h0000);
    send_request(OP_SETP, 4'd0, 4'd0, 4'd0, 1'b0, 16'h0000);
    send_request(OP_SETP, 4'd15, 4'd7, 4'd0, 1'b0, 16'h0000);
    send_request(OP_PICK, 4'd0, 4'd0, 4'd0, 1'b0, 16'hFFFF);
    send_request(OP_PICK, 4'd0, 4'd0, 4'd0, 1'b0, 16'h8000);
    send_request(OP_YIELD, 4'd0, 4'd0, 4'd0, 1'b1, 16'h0000);
    send_request(OP_YIELD, 4'd0, 4'd0, 4'd9, 1'b1, 16'h0000);
    send_request(OP_YIELD, 4'd0, 4'd0, 4'd15, 1'b0, 16'h0000);
    send_request(OP_TICK, 4'd0, 4'd0, 4'd0, 1'b0, 16'h0000);
    send_request(OP_TICK, 4'd0, 4'd0, 4'd0, 1'b1, 16'h0000);
    send_request(OP_TICK, 4'd0, 4'd0, 4'd0, 1'b1, 16'h0000);
    send_request(3'd6, 4'd0, 4'd0, 4'd0, 1'b1, 16'hFFFF);
    send_request(3'd7, 4'd15, 4'd15, 4'd15, 1'b1, 16'hFFFF);
    send_request(OP_DEQ, 4'd0, 4'd0, 4'd0, 1'b0, 16'h0000);
    send_request(OP_PICK, 4'd0, 4'd0, 4'd0, 1'b0, 16'h0001);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_quantum(16'd0);
        1: write_quantum(16'hFFFF);
        2: write_quantum(16'd1);
        3: write_quantum(16'($urandom_range(2, 6)));
        default: write_quantum(16'd3);
      endcase
      if (ph == 4) idling = 1'b0;
      for (int k = 0; k < 115; k++) random_request();
    end
    while (outstanding != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #4ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
